FILE: rtl/sha_pkg.sv
`default_nettype none
package sha_pkg;

  // one queued beat from the front part
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha_beat_t;

  localparam logic [7:0] PadMark = 8'h80;

  localparam logic [255:0] StartWords = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sha_queue.sv
`default_nettype none
module sha_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sha_pkg::sha_beat_t in_beat,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output sha_pkg::sha_beat_t     out_beat,
  output logic                   out_valid,
  input  wire logic              out_ready
);
  import sha_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  sha_beat_t slots [Depth];
  logic [AddrW-1:0] wr_ptr;
  logic [AddrW-1:0] rd_ptr;
  logic [AddrW:0]   count;
  logic push;
  logic pop;

  assign in_ready  = (count != (AddrW+1)'(Depth));
  assign out_valid = (count != '0);
  assign out_beat  = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AddrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AddrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_beat;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sha_core.sv
`default_nettype none
module sha_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sha_pkg::sha_beat_t beat,
  input  wire logic              beat_valid,
  output logic                   beat_ready,
  output logic [31:0]            digest_word,
  output logic [2:0]             word_number,
  output logic                   final_word,
  output logic                   out_valid,
  input  wire logic              out_ready
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_ROUND, ST_ADD, ST_EMIT
  } state_t;

  state_t      state;
  logic [31:0] chain [8];
  logic [31:0] work [8];
  logic [31:0] sched [16];
  logic [63:0] byte_total;
  logic [5:0]  round;
  logic        finishing;
  logic        pad_second;
  logic [2:0]  emit_idx;
  logic        data_block;

  logic [5:0]  pos;
  logic [63:0] bit_len;
  logic        last_pad;
  logic [31:0] wt;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] s0;
  logic [31:0] s1;
  logic [31:0] ea;
  logic [31:0] aa;
  logic        out_free;
  logic        emit_fire;

  assign pos = byte_total[5:0];
  assign bit_len = {byte_total[60:0], 3'b000};
  assign last_pad = pad_second || (pos < 6'd56);
  assign out_free = !out_valid || out_ready;
  assign emit_fire = (state == ST_EMIT) && out_free;
  assign beat_ready = (state == ST_IDLE);

  // message schedule and round function
  always_comb begin
    s0 = {sched[1][6:0], sched[1][31:7]} ^ {sched[1][17:0], sched[1][31:18]}
       ^ (sched[1] >> 3);
    s1 = {sched[14][16:0], sched[14][31:17]} ^ {sched[14][18:0], sched[14][31:19]}
       ^ (sched[14] >> 10);
    w_new = s1 + sched[9] + s0 + sched[0];
    wt = sched[0];
    ea = work[4];
    aa = work[0];
    t1 = work[7] + ({ea[5:0], ea[31:6]} ^ {ea[10:0], ea[31:11]} ^ {ea[24:0], ea[31:25]})
       + ((ea & work[5]) ^ (~ea & work[6])) + round_k(round) + wt;
    t2 = ({aa[1:0], aa[31:2]} ^ {aa[12:0], aa[31:13]} ^ {aa[21:0], aa[31:22]})
       + ((aa & work[1]) ^ (aa & work[2]) ^ (work[1] & work[2]));
  end

  // sequencer: byte load, padding, 64 rounds, chaining add, digest output
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      byte_total <= '0;
      out_valid  <= 1'b0;
      finishing  <= 1'b0;
      pad_second <= 1'b0;
      round      <= '0;
      emit_idx   <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= StartWords[255 - 32*i -: 32];
      end
      for (int i = 0; i < 16; i++) begin
        sched[i] <= '0;
      end
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (beat_valid) begin
            finishing <= beat.end_of_message;
            if (beat.has_byte) begin
              sched[pos[5:2]][31 - 8*pos[1:0] -: 8] <= beat.data_byte;
              byte_total <= byte_total + 64'd1;
              if (pos == 6'd63) begin
                for (int i = 0; i < 8; i++) work[i] <= chain[i];
                round <= '0;
                state <= ST_ROUND;
              end else if (beat.end_of_message) begin
                state <= ST_PAD;
              end
            end else if (beat.end_of_message) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          // mark, zero fill and, on the last padding block, length field in one step
          for (int b = 0; b < 64; b++) begin
            if (b >= 56 && last_pad) begin
              sched[b/4][31 - 8*(b%4) -: 8] <= bit_len[63 - 8*(b-56) -: 8];
            end else if (!pad_second && b == int'(pos)) begin
              sched[b/4][31 - 8*(b%4) -: 8] <= PadMark;
            end else if (pad_second || b > int'(pos)) begin
              sched[b/4][31 - 8*(b%4) -: 8] <= 8'h00;
            end
          end
          if (last_pad) begin
            finishing <= 1'b1;
            pad_second <= 1'b0;
          end else begin
            pad_second <= 1'b1;
          end
          for (int i = 0; i < 8; i++) work[i] <= chain[i];
          round <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) sched[i] <= sched[i+1];
          sched[15] <= w_new;
          work[7] <= work[6]; work[6] <= work[5]; work[5] <= work[4];
          work[4] <= work[3] + t1;
          work[3] <= work[2]; work[2] <= work[1]; work[1] <= work[0];
          work[0] <= t1 + t2;
          round <= round + 1'b1;
          if (round == 6'd63) state <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + work[i];
          emit_idx <= '0;
          // block filled by a byte that also ended the message still needs padding
          if (pad_second || (finishing && data_block)) begin
            state <= ST_PAD;
          end else if (finishing) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            digest_word <= chain[emit_idx];
            word_number <= emit_idx;
            final_word  <= (emit_idx == 3'd7);
            emit_idx    <= emit_idx + 1'b1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) chain[i] <= StartWords[255 - 32*i -: 32];
              byte_total <= '0;
              finishing  <= 1'b0;
              for (int i = 0; i < 16; i++) sched[i] <= '0;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // set when a beat's byte fills the block and starts a data compression
  always_ff @(posedge clk) begin
    if (rst) begin
      data_block <= 1'b0;
    end else if (state == ST_IDLE && beat_valid) begin
      data_block <= beat.has_byte && pos == 6'd63;
    end else if (state == ST_PAD) begin
      data_block <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sha256_byte_stream_hasher.sv
`default_nettype none
// SHA-256 of a byte stream, one byte per input beat. Beats pass through a
// two-entry queue into a sequencer that stores each byte in the block
// buffer and takes a new beat only while idle; a full block, and each
// padding block on the beat marked end_of_message, runs 64 rounds at one
// round per cycle followed by the chaining add. The eight digest words
// then leave one per cycle while out_ready allows, word 0 first.
module sha256_byte_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        end_of_message,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_number,
  output logic             final_word,
  output logic             out_valid,
  input  wire logic        out_ready
);
  import sha_pkg::*;

  sha_beat_t in_beat;
  sha_beat_t q_beat;
  logic      q_valid;
  logic      q_ready;

  assign in_beat = '{data_byte: data_byte, has_byte: has_byte,
                     end_of_message: end_of_message};

  // front: input queue
  sha_queue #(.Depth(2)) u_queue (
    .clk(clk), .rst(rst),
    .in_beat(in_beat), .in_valid(in_valid), .in_ready(in_ready),
    .out_beat(q_beat), .out_valid(q_valid), .out_ready(q_ready)
  );

  // back: compression engine
  sha_core u_core (
    .clk(clk), .rst(rst),
    .beat(q_beat), .beat_valid(q_valid), .beat_ready(q_ready),
    .digest_word(digest_word), .word_number(word_number),
    .final_word(final_word), .out_valid(out_valid), .out_ready(out_ready)
  );
endmodule
`default_nettype wire
